>>> design/spq_pkg.sv
// sorted priority queue package: widths, capacity defaults and codes
// no dependencies
`default_nettype none

package spq_pkg;

  localparam int SPQ_DATA_W        = 32;
  localparam int SPQ_PRIO_W        = 8;
  localparam int SPQ_STATUS_W      = 2;
  localparam int SPQ_CAPACITY      = 16;
  localparam int SPQ_PRIORITY_BITS = 8;
  localparam int SPQ_COUNT_W       = $clog2(SPQ_CAPACITY + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  typedef enum logic [SPQ_STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

endpackage

`default_nettype wire

>>> design/spq_in_if.sv
// request channel of the sorted priority queue: valid, ready and the request fields
// depends on spq_pkg
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
();

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [SPQ_DATA_W-1:0] item_data;
  logic [SPQ_PRIO_W-1:0]        item_priority;

  modport source (output valid, output op, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input op, input item_data, input item_priority,
                  output ready);

endinterface

`default_nettype wire

>>> design/spq_out_if.sv
// result channel of the sorted priority queue: valid, ready and the result fields
// depends on spq_pkg
`default_nettype none

interface spq_out_if
  import spq_pkg::*;
#(
  parameter int CNT_W = SPQ_COUNT_W
) ();

  logic                         valid;
  logic                         ready;
  logic [SPQ_STATUS_W-1:0]      status;
  logic signed [SPQ_DATA_W-1:0] removed_data;
  logic [SPQ_PRIO_W-1:0]        removed_priority;
  logic                         head_valid;
  logic signed [SPQ_DATA_W-1:0] head_data;
  logic [SPQ_PRIO_W-1:0]        head_priority;
  logic [CNT_W-1:0]             entry_count;

  modport source (output valid, output status, output removed_data,
                  output removed_priority, output head_valid, output head_data,
                  output head_priority, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_data,
                  input removed_priority, input head_valid, input head_data,
                  input head_priority, input entry_count, output ready);

endinterface

`default_nettype wire

>>> design/sorted_priority_queue.sv
// sorted priority queue top level: slot memory, insertion/removal sequencer, result register
// depends on spq_pkg, spq_in_if, spq_out_if
//
// usage:
//   in_ch carries one request: op enqueue (item_data, item_priority) or dequeue.
//   out_ch returns one result per request: status, removed entry, head and count.
//   entries sit sorted in a single-port-read slot memory; one compare/move step
//   per cycle walks the memory, so the block takes one request at a time
//   (in_ch.ready is high only while the sequencer is idle).
//   enqueue: the walk takes one step per entry moved up, then writes the new entry
//   (an empty queue takes the entry directly, with no walk)
//   dequeue: the walk shifts down each entry left after removal
//   full enqueue and empty dequeue move no entry.
//   the next request can be taken in the same cycle as the result appears.
//   the result sits in an output register; while the receiver stalls one further
//   request is taken and the sequencer holds in its last state until the register frees.
//   reset (rst_n low, synchronous) empties the queue; the slot memory itself
//   is not cleared, only the entry count.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY      = SPQ_CAPACITY,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
  input  wire         clk,
  input  wire         rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (PRIORITY_BITS < SPQ_PRIO_W) ? PRIORITY_BITS : SPQ_PRIO_W;

  typedef struct packed {
    logic signed [SPQ_DATA_W-1:0] data;
    logic [PW-1:0]                prio;
  } slot_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ENQ_CMP  = 8'b0000_0010,
    S_ENQ_PUT  = 8'b0000_0100,
    S_DEQ_TAKE = 8'b0000_1000,
    S_DEQ_SH   = 8'b0001_0000,
    S_HEAD_RD  = 8'b0010_0000,
    S_HEAD_CAP = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  slot_t mem [CAPACITY];
  slot_t rd_q;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  slot_t                        new_r, new_nxt;
  spq_status_t                  status_r, status_nxt;
  slot_t                        rem_r, rem_nxt;
  logic                         hvalid_r, hvalid_nxt;
  slot_t                        head_r, head_nxt;

  logic                         out_valid_r;
  spq_status_t                  o_status_r;
  slot_t                        o_rem_r, o_head_r;
  logic                         o_hvalid_r;
  logic [CW-1:0]                o_count_r;

  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  slot_t                        wr_data;
  logic                         load_out;
  logic [CW-1:0]                cnt_m1;
  logic [CW:0]                  idx_p2;

  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign cnt_m1      = count_r - CW'(1);
  assign idx_p2      = (CW+1)'(idx_r) + (CW+1)'(2);

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    status_nxt = status_r;
    rem_nxt    = rem_r;
    hvalid_nxt = hvalid_r;
    head_nxt   = head_r;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = new_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          new_nxt.data = in_ch.item_data;
          new_nxt.prio = in_ch.item_priority[PW-1:0];
          status_nxt   = ST_OK;
          rem_nxt      = '0;
          if (in_ch.op == OP_ENQ) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_HEAD_RD;
            end else if (count_r == '0) begin
              wr_en        = 1'b1;
              wr_addr      = '0;
              wr_data.data = in_ch.item_data;
              wr_data.prio = in_ch.item_priority[PW-1:0];
              count_nxt    = CW'(1);
              state_nxt    = S_HEAD_RD;
            end else begin
              idx_nxt   = count_r[AW-1:0];
              rd_addr   = cnt_m1[AW-1:0];
              state_nxt = S_ENQ_CMP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_HEAD_RD;
            end else begin
              rd_addr   = '0;
              state_nxt = S_DEQ_TAKE;
            end
          end
        end
      end
      S_ENQ_CMP: begin
        wr_en = 1'b1;
        if (rd_q.prio > new_r.prio) begin
          wr_data = rd_q;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_ENQ_PUT;
          end else begin
            rd_addr = idx_r - AW'(2);
          end
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_HEAD_RD;
        end
      end
      S_ENQ_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_HEAD_RD;
      end
      S_DEQ_TAKE: begin
        rem_nxt   = rd_q;
        count_nxt = cnt_m1;
        if (count_r == CW'(1)) begin
          state_nxt = S_HEAD_RD;
        end else begin
          rd_addr   = AW'(1);
          idx_nxt   = '0;
          state_nxt = S_DEQ_SH;
        end
      end
      S_DEQ_SH: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
        if ((CW+1)'(idx_r) + (CW+1)'(1) == (CW+1)'(count_r)) begin
          state_nxt = S_HEAD_RD;
        end else begin
          rd_addr = idx_p2[AW-1:0];
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_HEAD_RD: begin
        rd_addr = '0;
        if (count_r == '0) begin
          hvalid_nxt = 1'b0;
          head_nxt   = '0;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_HEAD_CAP;
        end
      end
      S_HEAD_CAP: begin
        hvalid_nxt = 1'b1;
        head_nxt   = rd_q;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    new_r    <= new_nxt;
    status_r <= status_nxt;
    rem_r    <= rem_nxt;
    hvalid_r <= hvalid_nxt;
    head_r   <= head_nxt;
    if (load_out) begin
      o_status_r <= status_r;
      o_rem_r    <= rem_r;
      o_hvalid_r <= hvalid_r;
      o_head_r   <= head_r;
      o_count_r  <= count_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.removed_data     = o_rem_r.data;
  assign out_ch.removed_priority = SPQ_PRIO_W'(o_rem_r.prio);
  assign out_ch.head_valid       = o_hvalid_r;
  assign out_ch.head_data        = o_head_r.data;
  assign out_ch.head_priority    = SPQ_PRIO_W'(o_head_r.prio);
  assign out_ch.entry_count      = o_count_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench for the sorted priority queue: directed and random request streams with
// random idling on both channels, every result checked against a sorted-list model
// depends on spq_pkg, spq_in_if, spq_out_if and sorted_priority_queue
`default_nettype none

module testbench;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    spq_status_t                  status;
    logic signed [SPQ_DATA_W-1:0] removed_data;
    logic [SPQ_PRIO_W-1:0]        removed_priority;
    logic                         head_valid;
    logic signed [SPQ_DATA_W-1:0] head_data;
    logic [SPQ_PRIO_W-1:0]        head_priority;
    logic [SPQ_COUNT_W-1:0]       entry_count;
  } spq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [SPQ_DATA_W-1:0] held_data [SPQ_CAPACITY];
  logic [SPQ_PRIO_W-1:0]        held_prio [SPQ_CAPACITY];
  int                           held_count;
  spq_result_t                  pending_results [$];
  int                           mismatch_count;
  int                           sent_count;
  int                           stall_left;
  int                           quiet_cycles;
  bit                           calm;

  initial begin
    forever #6 clk = ~clk;
  end

  // sorted insert after equal priorities, removal from the head
  function automatic spq_result_t apply_queue_op(spq_op_t op, logic signed [SPQ_DATA_W-1:0] data,
                                                 logic [SPQ_PRIO_W-1:0] prio);
    spq_result_t           r;
    logic [SPQ_PRIO_W-1:0] p;
    int                    pos;
    int                    i;
    p = prio;
    for (i = SPQ_PRIORITY_BITS; i < SPQ_PRIO_W; i++)
      p[i] = 1'b0;
    r.status           = ST_OK;
    r.removed_data     = '0;
    r.removed_priority = '0;
    if (op == OP_ENQ) begin
      if (held_count >= SPQ_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= p)
          pos++;
        for (i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = data;
        held_prio[pos] = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_data     = held_data[0];
        r.removed_priority = held_prio[0];
        for (i = 0; i + 1 < held_count; i++) begin
          held_data[i] = held_data[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held_count--;
      end
    end
    r.head_valid    = (held_count > 0);
    r.head_data     = (held_count > 0) ? held_data[0] : '0;
    r.head_priority = (held_count > 0) ? held_prio[0] : '0;
    r.entry_count   = held_count[SPQ_COUNT_W-1:0];
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(spq_op_t op, logic signed [SPQ_DATA_W-1:0] data,
                              logic [SPQ_PRIO_W-1:0] prio);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.op            = op;
    in_ch.item_data     = data;
    in_ch.item_priority = prio;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_queue_op(op, data, prio));
    sent_count++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(1, 14) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    spq_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("unexpected result: st=%0d cnt=%0d", out_ch.status, out_ch.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.removed_data !== want.removed_data ||
            out_ch.removed_priority !== want.removed_priority ||
            out_ch.head_valid !== want.head_valid || out_ch.head_data !== want.head_data ||
            out_ch.head_priority !== want.head_priority ||
            out_ch.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("mismatch: expected st=%0d rem=%0d/%0d head=%0b %0d/%0d cnt=%0d, got st=%0d rem=%0d/%0d head=%0b %0d/%0d cnt=%0d",
                     want.status, want.removed_data, want.removed_priority, want.head_valid,
                     want.head_data, want.head_priority, want.entry_count,
                     out_ch.status, out_ch.removed_data, out_ch.removed_priority,
                     out_ch.head_valid, out_ch.head_data, out_ch.head_priority,
                     out_ch.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_dequeue_empty();
    send_request(OP_DEQ, 32'sh0, 8'h00);
    send_request(OP_DEQ, -32'sd1, 8'hff);
  endtask

  task automatic test_field_extremes();
    send_request(OP_ENQ, 32'sh7fff_ffff, 8'hff);
    send_request(OP_ENQ, 32'sh8000_0000, 8'h00);
    send_request(OP_ENQ, -32'sd1, 8'h00);
    send_request(OP_ENQ, 32'sh0, 8'h80);
    send_request(OP_ENQ, 32'sh1, 8'hff);
    send_request(OP_DEQ, 32'sh5555_5555, 8'haa);
    send_request(OP_DEQ, 32'shaaaa_aaaa, 8'h55);
  endtask

  task automatic test_full_queue();
    while (held_count < SPQ_CAPACITY)
      send_request(OP_ENQ, $urandom, 8'($urandom_range(0, 3)));
    send_request(OP_ENQ, 32'sh7fff_ffff, 8'h00);
    send_request(OP_ENQ, 32'sh8000_0000, 8'hff);
    send_request(OP_DEQ, 32'sh0, 8'h00);
    send_request(OP_DEQ, 32'sh0, 8'h00);
  endtask

  // runs biased towards filling, draining or neither; priorities narrow (many ties), wide or at the extremes
  task automatic run_mixed_traffic(int count);
    int                           goal;
    int                           run_len;
    int                           enq_weight;
    int                           prio_mode;
    int                           rounds;
    spq_op_t                      op;
    logic signed [SPQ_DATA_W-1:0] data;
    logic [SPQ_PRIO_W-1:0]        prio;
    goal   = sent_count + count;
    rounds = 0;
    while (sent_count < goal) begin
      run_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: enq_weight = 85;
        1: enq_weight = 15;
        default: enq_weight = 50;
      endcase
      prio_mode = $urandom_range(0, 2);
      repeat (run_len) begin
        if (sent_count < goal) begin
          op = ($urandom_range(0, 99) < enq_weight) ? OP_ENQ : OP_DEQ;
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
              0: data = 32'sh7fff_ffff;
              1: data = 32'sh8000_0000;
              2: data = 32'sh0;
              default: data = -32'sd1;
            endcase
          end else begin
            data = $urandom;
          end
          case (prio_mode)
            0: prio = 8'($urandom_range(0, 3));
            1: prio = 8'($urandom_range(0, 255));
            default: prio = $urandom_range(0, 1) ? 8'hff - 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 1));
          endcase
          send_request(op, data, prio);
        end
      end
      rounds++;
      // hold the requests back until the queue has answered everything
      if (rounds % 6 == 0) begin
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_mixed_traffic(800);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    run_mixed_traffic(130);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_ENQ;
    in_ch.item_data     = '0;
    in_ch.item_priority = '0;
    calm                = 1'b0;
    held_count          = 0;
    sent_count          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_dequeue_empty();
    test_field_extremes();
    test_full_queue();
    test_random_traffic();
    test_back_to_back();

    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
    end
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
